[src/point_transform_box_reject_defines.svh]
// ----------------------------------------------------------------------------
// point_transform_box_reject_defines
// assertion macros shared by the point transform block
// ----------------------------------------------------------------------------
`ifndef POINT_TRANSFORM_BOX_REJECT_DEFINES_SVH
`define POINT_TRANSFORM_BOX_REJECT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PTBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PTBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ptbr_pkg.sv]
// ----------------------------------------------------------------------------
// ptbr_pkg
// types and constants of the point transform and body box filter
// ----------------------------------------------------------------------------
`default_nettype none

package ptbr_pkg;

  localparam int COORD_BITS     = 24;
  localparam int COEF_FRAC_BITS = 14;

  // q2.x coefficients: two integer bits including sign
  localparam int COEF_BITS  = COEF_FRAC_BITS + 2;
  localparam int TRANS_BITS = 20;
  localparam int INT_BITS   = 16;

  localparam int ROT_W   = 3 * COEF_BITS;
  localparam int TRANS_W = 3 * TRANS_BITS;
  localparam int BOX_W   = 2 * COORD_BITS;

  localparam int CFG_W_RT   = (ROT_W > TRANS_W) ? ROT_W : TRANS_W;
  localparam int CFG_DATA_W = (CFG_W_RT > BOX_W) ? CFG_W_RT : BOX_W;
  localparam int NUM_REGS   = 7;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS + 1);

  // datapath widths
  localparam int PROD_W  = COORD_BITS + COEF_BITS;
  localparam int SUM_W   = PROD_W + 2;
  localparam int SHIFT_W = SUM_W - COEF_FRAC_BITS;
  localparam int ADJ_W   = ((SHIFT_W > TRANS_BITS) ? SHIFT_W : TRANS_BITS) + 1;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEF_FRAC_BITS - 1);

  localparam logic signed [ADJ_W-1:0] SAT_MAX =
    {{(ADJ_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [ADJ_W-1:0] SAT_MIN =
    {{(ADJ_W - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X   = CFG_IDX_W'(0),
    REG_ROT_Y   = CFG_IDX_W'(1),
    REG_ROT_Z   = CFG_IDX_W'(2),
    REG_TRANS   = CFG_IDX_W'(3),
    REG_BOX_X   = CFG_IDX_W'(4),
    REG_BOX_Y   = CFG_IDX_W'(5),
    REG_BOX_Z   = CFG_IDX_W'(6)
  } cfg_reg_e;

  // identity rotation after reset
  localparam logic [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(1) << COEF_FRAC_BITS;
  localparam logic [COEF_BITS-1:0] COEF_ZERO = '0;
  localparam logic [ROT_W-1:0] ROT_X_RST = {COEF_ZERO, COEF_ZERO, COEF_ONE};
  localparam logic [ROT_W-1:0] ROT_Y_RST = {COEF_ZERO, COEF_ONE, COEF_ZERO};
  localparam logic [ROT_W-1:0] ROT_Z_RST = {COEF_ONE, COEF_ZERO, COEF_ZERO};
  localparam logic [TRANS_W-1:0] TRANS_RST = '0;

  // body box after reset: x -0.7..0.4 m, y -0.4..0.4 m, z -0.6..0.1 m
  localparam logic [COORD_BITS-1:0] BOX_X_MIN_RST = COORD_BITS'(-2867);
  localparam logic [COORD_BITS-1:0] BOX_X_MAX_RST = COORD_BITS'(1638);
  localparam logic [COORD_BITS-1:0] BOX_Y_MIN_RST = COORD_BITS'(-1638);
  localparam logic [COORD_BITS-1:0] BOX_Y_MAX_RST = COORD_BITS'(1638);
  localparam logic [COORD_BITS-1:0] BOX_Z_MIN_RST = COORD_BITS'(-2458);
  localparam logic [COORD_BITS-1:0] BOX_Z_MAX_RST = COORD_BITS'(410);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [INT_BITS-1:0]          point_intensity;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic [INT_BITS-1:0]          out_intensity;
  } result_t;

  // decoded configuration, index 0 is x (or first column)
  typedef struct packed {
    logic [2:0][2:0][COEF_BITS-1:0] rot;
    logic [2:0][TRANS_BITS-1:0]     trans;
    logic [2:0][COORD_BITS-1:0]     box_min;
    logic [2:0][COORD_BITS-1:0]     box_max;
  } cfg_t;

  // product stage contents, prod[row][col]
  typedef struct packed {
    logic                        valid;
    logic [2:0][2:0][PROD_W-1:0] prod;
    logic [INT_BITS-1:0]         intensity;
  } prod_t;

endpackage

`default_nettype wire

[src/ptbr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ptbr_cfg_regs
// configuration register file: rotation rows, translation, box bounds
// ----------------------------------------------------------------------------
`default_nettype none

module ptbr_cfg_regs import ptbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [ROT_W-1:0]   rot_q [3];
  logic [TRANS_W-1:0] trans_q;
  logic [BOX_W-1:0]   box_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= ROT_X_RST;
      rot_q[1] <= ROT_Y_RST;
      rot_q[2] <= ROT_Z_RST;
      trans_q  <= TRANS_RST;
      box_q[0] <= {BOX_X_MAX_RST, BOX_X_MIN_RST};
      box_q[1] <= {BOX_Y_MAX_RST, BOX_Y_MIN_RST};
      box_q[2] <= {BOX_Z_MAX_RST, BOX_Z_MIN_RST};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROT_X: rot_q[0] <= cfg_data_i[ROT_W-1:0];
        REG_ROT_Y: rot_q[1] <= cfg_data_i[ROT_W-1:0];
        REG_ROT_Z: rot_q[2] <= cfg_data_i[ROT_W-1:0];
        REG_TRANS: trans_q  <= cfg_data_i[TRANS_W-1:0];
        REG_BOX_X: box_q[0] <= cfg_data_i[BOX_W-1:0];
        REG_BOX_Y: box_q[1] <= cfg_data_i[BOX_W-1:0];
        REG_BOX_Z: box_q[2] <= cfg_data_i[BOX_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cfg_o.rot[a]     = rot_q[a];
      cfg_o.box_min[a] = box_q[a][COORD_BITS-1:0];
      cfg_o.box_max[a] = box_q[a][BOX_W-1:COORD_BITS];
    end
    cfg_o.trans = trans_q;
  end

endmodule

`default_nettype wire

[src/ptbr_mult.sv]
// ----------------------------------------------------------------------------
// ptbr_mult
// product stage: nine coefficient by coordinate products, registered
// ----------------------------------------------------------------------------
`default_nettype none

module ptbr_mult import ptbr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  point_t point_i,
  input  cfg_t   cfg_i,
  output prod_t  prod_o
);

  logic                        valid_q;
  logic [2:0][2:0][PROD_W-1:0] prod_d, prod_q;
  logic [INT_BITS-1:0]         int_q;

  always_comb begin
    logic signed [COORD_BITS-1:0] coord [3];
    logic signed [COEF_BITS-1:0]  coef;
    logic signed [PROD_W-1:0]     p;
    coord[0] = point_i.point_x;
    coord[1] = point_i.point_y;
    coord[2] = point_i.point_z;
    coef = '0;
    p    = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef         = cfg_i.rot[r][c];
        p            = PROD_W'(coef) * PROD_W'(coord[c]);
        prod_d[r][c] = p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      prod_q <= prod_d;
      int_q  <= point_i.point_intensity;
    end
  end

  assign prod_o.valid     = valid_q;
  assign prod_o.prod      = prod_q;
  assign prod_o.intensity = int_q;

endmodule

`default_nettype wire

[src/ptbr_crop.sv]
// ----------------------------------------------------------------------------
// ptbr_crop
// result stage: row sums, rounding, offset, clamp and body box test
// ----------------------------------------------------------------------------
`default_nettype none

module ptbr_crop import ptbr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  prod_t   prod_i,
  input  cfg_t    cfg_i,
  output logic    out_valid_o,
  output result_t out_word_o
);

  logic    out_valid_q;
  result_t out_word_q;
  result_t res;
  logic    in_box;

  always_comb begin
    logic signed [PROD_W-1:0]     pv;
    logic signed [SUM_W-1:0]      acc;
    logic signed [SHIFT_W-1:0]    sh;
    logic signed [TRANS_BITS-1:0] tr;
    logic signed [ADJ_W-1:0]      adj;
    logic signed [COORD_BITS-1:0] q [3];
    logic signed [COORD_BITS-1:0] mn;
    logic signed [COORD_BITS-1:0] mx;
    pv     = '0;
    acc    = '0;
    sh     = '0;
    tr     = '0;
    adj    = '0;
    mn     = '0;
    mx     = '0;
    in_box = 1'b1;
    for (int r = 0; r < 3; r++) begin
      acc = ROUND_HALF;
      for (int c = 0; c < 3; c++) begin
        pv  = prod_i.prod[r][c];
        acc = acc + SUM_W'(pv);
      end
      // arithmetic shift keeps the top bits
      sh  = acc[SUM_W-1:COEF_FRAC_BITS];
      tr  = cfg_i.trans[r];
      adj = ADJ_W'(sh) + ADJ_W'(tr);
      if (adj > SAT_MAX) begin
        q[r] = SAT_MAX[COORD_BITS-1:0];
      end else if (adj < SAT_MIN) begin
        q[r] = SAT_MIN[COORD_BITS-1:0];
      end else begin
        q[r] = adj[COORD_BITS-1:0];
      end
      // strict bounds, so an empty box never drops anything
      mn = cfg_i.box_min[r];
      mx = cfg_i.box_max[r];
      if (!((q[r] > mn) && (q[r] < mx))) begin
        in_box = 1'b0;
      end
    end
    res.out_x         = q[0];
    res.out_y         = q[1];
    res.out_z         = q[2];
    res.out_intensity = prod_i.intensity;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= prod_i.valid && !in_box;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && prod_i.valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

[src/point_transform_box_reject.sv]
// ----------------------------------------------------------------------------
// point_transform_box_reject
// rigid transform of lidar points with rejection of points inside the body box
// ----------------------------------------------------------------------------
//  channel   dir   handshake                 word
//  in        in    in_valid_i / in_stall_o   point_t  (x, y, z, intensity)
//  out       out   out_valid_o / out_stall_i result_t (x, y, z, intensity)
//  cfg       in    cfg_valid_i / cfg_ready_o index + data, always ready
//
//  one point per cycle while the output is not stalled; a point passes through
//  the input, product and result registers in series on its way to the output.
//  points inside the body box leave a bubble instead of a word.
//  reset clears the stage valid bits and loads identity rotation, zero offset
//  and the default body box; no clearing pass.
//  stages advance whenever the stage ahead is empty or moving, so the input
//  stalls only when all three registers hold words and the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_transform_box_reject_defines.svh"

module point_transform_box_reject import ptbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  point_t                in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output result_t               out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t   cfg;
  prod_t  prod;
  logic   in_v_q;
  point_t in_word_q;
  logic   en_out, en_prod, en_in;

  assign cfg_ready_o = 1'b1;

  ptbr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // move-enables, output side first
  assign en_out     = !out_valid_o || !out_stall_i;
  assign en_prod    = !prod.valid || en_out;
  assign en_in      = !in_v_q || en_prod;
  assign in_stall_o = !en_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en_in) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  ptbr_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_prod),
    .valid_i (in_v_q),
    .point_i (in_word_q),
    .cfg_i   (cfg),
    .prod_o  (prod)
  );

  ptbr_crop u_crop (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_out),
    .prod_i      (prod),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // input stalls only with every stage full
  `PTBR_ASSERT_NOW(a_stall_full, in_stall_o, in_v_q && prod.valid && out_valid_o, "stall with a free stage")

  // an accepted word lands in the input register
  `PTBR_ASSERT_NEXT(a_in_capture, in_valid_i && !in_stall_o, in_v_q, "accepted word lost")

  // no output word appears without a product stage word behind it
  `PTBR_ASSERT_NEXT(a_no_phantom, !prod.valid && en_out, !out_valid_o, "output word from nothing")

endmodule

`default_nettype wire
